// ===== rtl/bqf_pkg.sv =====
// ----------------------------------------------------------------------------
// bqf_pkg - shared types and constants for the biquad filter
// Sample and coefficient widths, register indexes, item kinds and the
// structs that carry history and coefficients between modules.
// ----------------------------------------------------------------------------
package bqf_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 28;
    localparam int NUM_COEFS      = 5;
    localparam int CFG_IDX_BITS   = 3;

    // exact product and exact five-term sum plus rounding constant
    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 3;
    // width of the sum after dropping the fraction bits
    localparam int WIDE_W = ACC_W - COEF_FRAC_BITS;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        COEF_BITS'(1) << COEF_FRAC_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FF_COEF_0 = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FF_COEF_1 = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FF_COEF_2 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FB_COEF_1 = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FB_COEF_2 = CFG_IDX_BITS'(4);

    // item kinds
    localparam logic KIND_FILTER = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // saturation limits
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] prev_in_1;
        logic signed [SAMPLE_BITS-1:0] prev_in_2;
        logic signed [SAMPLE_BITS-1:0] prev_out_1;
        logic signed [SAMPLE_BITS-1:0] prev_out_2;
    } t_history;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] ff_coef_0;
        logic signed [COEF_BITS-1:0] ff_coef_1;
        logic signed [COEF_BITS-1:0] ff_coef_2;
        logic signed [COEF_BITS-1:0] fb_coef_1;
        logic signed [COEF_BITS-1:0] fb_coef_2;
    } t_coefs;

endpackage

// ===== rtl/bqf_datapath.sv =====
// ----------------------------------------------------------------------------
// bqf_datapath - one biquad output sample
// Five products summed exactly, rounded half up, then saturated.
// ----------------------------------------------------------------------------
module bqf_datapath (
    input  logic signed [bqf_pkg::SAMPLE_BITS-1:0] i_sample,
    input  bqf_pkg::t_history                      i_hist,
    input  bqf_pkg::t_coefs                        i_coefs,
    output logic signed [bqf_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                   o_clipped
);
    import bqf_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] p_ff0, p_ff1, p_ff2, p_fb1, p_fb2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [WIDE_W-1:0] y_wide;
    logic [WIDE_W-SAMPLE_BITS:0] upper;
    logic over_pos, over_neg;

    assign p_ff0 = i_coefs.ff_coef_0 * i_sample;
    assign p_ff1 = i_coefs.ff_coef_1 * i_hist.prev_in_1;
    assign p_ff2 = i_coefs.ff_coef_2 * i_hist.prev_in_2;
    assign p_fb1 = i_coefs.fb_coef_1 * i_hist.prev_out_1;
    assign p_fb2 = i_coefs.fb_coef_2 * i_hist.prev_out_2;

    assign acc = ACC_W'(p_ff0) + ACC_W'(p_ff1) + ACC_W'(p_ff2)
               - ACC_W'(p_fb1) - ACC_W'(p_fb2) + ROUND_HALF;

    // floor after adding half an lsb
    assign y_wide = acc[ACC_W-1:COEF_FRAC_BITS];

    // bits above the sample's sign must all match the sign
    assign upper    = y_wide[WIDE_W-1:SAMPLE_BITS-1];
    assign over_pos = !y_wide[WIDE_W-1] && (|upper);
    assign over_neg =  y_wide[WIDE_W-1] && !(&upper);

    always_comb begin
        if (over_pos) begin
            o_sample = SAT_MAX;
        end else if (over_neg) begin
            o_sample = SAT_MIN;
        end else begin
            o_sample = y_wide[SAMPLE_BITS-1:0];
        end
    end

    assign o_clipped = over_pos || over_neg;

endmodule

// ===== rtl/biquad_iir_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_iir_filter - second-order direct form I iir filter
// Fixed-point biquad with Q4.28 coefficients, rounding and saturation.
// ----------------------------------------------------------------------------
// usage
//  - input channel (i_in_valid / o_in_ready): one item per transfer, i_kind
//    selects filtering of i_sample_in or a flush of the filter history
//  - output channel (o_out_valid / i_out_ready): one result per filtered
//    sample, o_filtered_out rounded and saturated, o_clipped set on saturation
//  - a flush clears the two input and two output history taps, keeps the
//    coefficients and produces no result
//  - configuration: i_cfg_we writes i_cfg_data into coefficient i_cfg_index
//    (0 b0, 1 b1, 2 b2, 3 a1, 4 a2), higher indexes are ignored; write only
//    while the filter is idle
//  - path: an item passes the input register, then the result register, and
//    o_out_valid rises once the result register is loaded
//  - throughput: one item per cycle when not stalled; the feedback path (five
//    products, sum, round, saturate) is combinational from the input register
//  - a stalled receiver holds the result register; one more filtered sample
//    waits in the input register, after which o_in_ready drops (flushes pass)
//  - reset (synchronous, active low) empties both registers, clears history
//    and loads b0 = 1.0 with all other coefficients zero (pass-through)
// ----------------------------------------------------------------------------
module biquad_iir_filter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_kind,
    input  logic signed [bqf_pkg::SAMPLE_BITS-1:0] i_sample_in,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [bqf_pkg::SAMPLE_BITS-1:0] o_filtered_out,
    output logic                                   o_clipped,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [bqf_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [bqf_pkg::COEF_BITS-1:0]          i_cfg_data
);
    import bqf_pkg::*;

    // input register
    logic                          r_s1_valid;
    logic                          r_s1_kind;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;

    // filter state
    t_history r_hist;
    t_coefs   r_coefs;

    // result register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_filtered_out;
    logic                          r_clipped;

    logic                          in_xfer;
    logic                          out_xfer;
    logic                          s1_advance;
    logic                          s1_result;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic                          clip_next;

    // a flush needs no result slot, so it always leaves the input register
    assign s1_advance = r_s1_valid &&
                        (r_s1_kind == KIND_FLUSH || !r_out_valid || i_out_ready);
    assign s1_result  = s1_advance && (r_s1_kind == KIND_FILTER);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;

    bqf_datapath u_datapath (
        .i_sample  (r_s1_sample),
        .i_hist    (r_hist),
        .i_coefs   (r_coefs),
        .o_sample  (y_next),
        .o_clipped (clip_next)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_kind   <= i_kind;
            r_s1_sample <= i_sample_in;
        end
    end

    // history: shift on a filtered sample, clear on a flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (s1_advance) begin
            if (r_s1_kind == KIND_FLUSH) begin
                r_hist <= '0;
            end else begin
                r_hist.prev_in_2  <= r_hist.prev_in_1;
                r_hist.prev_in_1  <= r_s1_sample;
                r_hist.prev_out_2 <= r_hist.prev_out_1;
                r_hist.prev_out_1 <= y_next;
            end
        end
    end

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.ff_coef_0 <= COEF_ONE;
            r_coefs.ff_coef_1 <= '0;
            r_coefs.ff_coef_2 <= '0;
            r_coefs.fb_coef_1 <= '0;
            r_coefs.fb_coef_2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FF_COEF_0: r_coefs.ff_coef_0 <= i_cfg_data;
                CFG_FF_COEF_1: r_coefs.ff_coef_1 <= i_cfg_data;
                CFG_FF_COEF_2: r_coefs.ff_coef_2 <= i_cfg_data;
                CFG_FB_COEF_1: r_coefs.fb_coef_1 <= i_cfg_data;
                CFG_FB_COEF_2: r_coefs.fb_coef_2 <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_result) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_result) begin
            r_filtered_out <= y_next;
            r_clipped      <= clip_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_filtered_out = r_filtered_out;
    assign o_clipped      = r_clipped;

endmodule

// ===== rtl/bqf_checker.sv =====
// ----------------------------------------------------------------------------
// bqf_checker - port-level checks for the biquad filter
// Watches the top level's ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module bqf_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   o_in_ready,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic signed [bqf_pkg::SAMPLE_BITS-1:0] o_filtered_out,
    input logic                                   o_clipped
);
    import bqf_pkg::*;

    // a pending result is held until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_filtered_out)
                                        && $stable(o_clipped))
        else $error("result dropped or changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a clipped result sits at one of the saturation limits
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |->
            (o_filtered_out == SAT_MAX) || (o_filtered_out == SAT_MIN))
        else $error("clipped result not at a saturation limit");

    // with no result pending nothing can block the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind biquad_iir_filter bqf_checker u_bqf_checker (.*);
